@@ hdl/quadratic_probe_hash_table_macros.svh @@
// assertion macros for the quadratic probe hash table
// no dependencies; included by the top level only
`ifndef QUADRATIC_PROBE_HASH_TABLE_MACROS_SVH
`define QUADRATIC_PROBE_HASH_TABLE_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define QPHT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qpht: same-cycle check failed");

// next-cycle implication
`define QPHT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qpht: next-cycle check failed");

`else

`define QPHT_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define QPHT_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ hdl/qpht_pkg.sv @@
// shared types and constants of the quadratic probe hash table
// no dependencies; imported by every module of the block
package qpht_pkg;

  localparam int SLOTS  = 64;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;
  localparam int KEY_W  = 48;
  localparam int DIGITS = 12;
  localparam int SUM_W  = 15;
  localparam int QDEPTH = 2;

  localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;
  localparam logic [CNT_W-1:0] CNT_MAX   = 7'd64;

  // opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_DELETED   = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // classified item handed from front to back
  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] home;
    logic [CNT_W-1:0] count;
  } job_t;

endpackage

@@ hdl/qpht_front.sv @@
// front end: accepts items, folds the key and finds the home slot
// depends on qpht_pkg
module qpht_front import qpht_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic             opcode,
  input  logic [KEY_W-1:0] key_digits,
  input  logic [CNT_W-1:0] slot_count,
  output logic             q_push,
  input  logic             q_full,
  output job_t             q_data
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_FOLD = 2'd1;
  localparam logic [1:0] F_DIV  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;
  localparam logic [3:0] DIV_LAST = 4'(SUM_W - 1);

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic             op;
  logic [KEY_W-1:0] key;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] dvd;
  logic [CNT_W-1:0] rem;
  logic [3:0]       bit_cnt;
  logic [CNT_W-1:0] cnt_eff;
  logic [SUM_W-1:0] fold_sum;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   rem_next;

  // digit groups of 4, 3, 3 and 2 digits read as decimal numbers, then summed
  function automatic logic [SUM_W-1:0] fold_key(input logic [KEY_W-1:0] k);
    logic [SUM_W-1:0] g [4];
    logic [3:0]       nib;
    int               grp;
    g[0] = '0;
    g[1] = '0;
    g[2] = '0;
    g[3] = '0;
    for (int d = 0; d < DIGITS; d++) begin
      nib = k[KEY_W-1-4*d -: 4];
      grp = (d <= 3) ? 0 : (d <= 6) ? 1 : (d <= 9) ? 2 : 3;
      g[grp] = SUM_W'(g[grp] * SUM_W'(10)) + SUM_W'(nib);
    end
    return g[0] + g[1] + g[2] + g[3];
  endfunction

  // clamp the configured count into 1..SLOTS
  always_comb begin
    cnt_eff = slot_count;
    if (slot_count == '0) cnt_eff = CNT_W'(1);
    else if (slot_count > CNT_MAX) cnt_eff = CNT_MAX;
  end

  assign fold_sum = fold_key(key);

  // one restoring remainder step a cycle
  always_comb begin
    trial = {rem, dvd[SUM_W-1]};
    if (trial >= {1'b0, cnt}) rem_next = trial - {1'b0, cnt};
    else rem_next = trial;
  end

  // state sequencing
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (push) state_next = F_FOLD;
      F_FOLD: state_next = F_DIV;
      F_DIV:  if (bit_cnt == DIV_LAST) state_next = F_PUSH;
      F_PUSH: if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item and divider registers
  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        op  <= opcode;
        key <= key_digits;
        cnt <= cnt_eff;
      end
      F_FOLD: begin
        dvd     <= fold_sum;
        rem     <= '0;
        bit_cnt <= '0;
      end
      F_DIV: begin
        rem     <= rem_next[CNT_W-1:0];
        dvd     <= {dvd[SUM_W-2:0], 1'b0};
        bit_cnt <= bit_cnt + 4'd1;
      end
      default: begin
      end
    endcase
  end

  assign full         = (state != F_IDLE);
  assign q_push       = (state == F_PUSH) && !q_full;
  assign q_data.op    = op;
  assign q_data.key   = key;
  assign q_data.home  = rem[IDX_W-1:0];
  assign q_data.count = cnt;

endmodule

@@ hdl/qpht_queue.sv @@
// short queue of classified items between front and back
// depends on qpht_pkg
module qpht_queue import qpht_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  job_t wr_data,
  output logic q_full,
  input  logic rd,
  output job_t rd_data,
  output logic q_empty
);

  localparam int PTR_W = $clog2(QDEPTH);

  job_t             ent [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;

  assign q_full  = (fill == (PTR_W+1)'(QDEPTH));
  assign q_empty = (fill == '0);
  assign rd_data = ent[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + PTR_W'(1);
      if (rd) rd_ptr <= rd_ptr + PTR_W'(1);
      if (wr && !rd) fill <= fill + (PTR_W+1)'(1);
      else if (rd && !wr) fill <= fill - (PTR_W+1)'(1);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (wr) ent[wr_ptr] <= wr_data;
  end

endmodule

@@ hdl/qpht_back.sv @@
// back end: probes the slot table and holds the result item
// depends on qpht_pkg
module qpht_back import qpht_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  job_t             q_data,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output logic [1:0]       status,
  output logic [IDX_W-1:0] slot_index
);

  localparam logic B_IDLE  = 1'b0;
  localparam logic B_PROBE = 1'b1;

  logic             state;
  job_t             job;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] step;
  logic [CNT_W-1:0] issue_cnt;
  logic             cmp_valid;
  logic             cmp_last;
  logic [IDX_W-1:0] cmp_pos;
  logic [KEY_W-1:0] rd_key;
  logic [SLOTS-1:0] used;
  logic             out_valid;
  logic [1:0]       out_status;
  logic [IDX_W-1:0] out_index;
  logic [KEY_W-1:0] key_mem [SLOTS];

  logic             start;
  logic             issue;
  logic             hit;
  logic             done;
  logic             mem_we;
  logic [CNT_W-1:0] pos_sum;
  logic [IDX_W-1:0] pos_next;
  logic [CNT_W-1:0] step_sum;
  logic [CNT_W-1:0] step_red;
  logic [IDX_W-1:0] step_next;

  assign start = (state == B_IDLE) && !q_empty && !out_valid;
  assign q_pop = start;
  assign issue = (state == B_PROBE) && (issue_cnt != job.count);

  // compare stage: free slot for insert, matching used slot for delete
  always_comb begin
    if (job.op == OP_INSERT) hit = cmp_valid && !used[cmp_pos];
    else hit = cmp_valid && used[cmp_pos] && (rd_key == job.key);
  end

  assign done   = (state == B_PROBE) && cmp_valid && (hit || cmp_last);
  assign mem_we = (state == B_PROBE) && hit && (job.op == OP_INSERT);

  // next probe position: home + i*i stepped by odd increments mod count
  always_comb begin
    pos_sum = {1'b0, pos} + {1'b0, step};
    if (pos_sum >= job.count) pos_next = IDX_W'(pos_sum - job.count);
    else pos_next = pos_sum[IDX_W-1:0];
    step_sum = {1'b0, step} + CNT_W'(2);
    step_red = step_sum;
    if (step_red >= job.count) step_red = step_red - job.count;
    if (step_red >= job.count) step_red = step_red - job.count;
    step_next = step_red[IDX_W-1:0];
  end

  // control: probe sequencing, slot flags and result hand-off
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
      used      <= '0;
    end else begin
      if (pop && out_valid) out_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          cmp_valid <= 1'b0;
          if (start) state <= B_PROBE;
        end
        B_PROBE: begin
          if (done) begin
            state     <= B_IDLE;
            cmp_valid <= 1'b0;
            out_valid <= 1'b1;
            if (hit) used[cmp_pos] <= (job.op == OP_INSERT);
          end else begin
            cmp_valid <= issue;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // item payload, probe position and result fields
  always_ff @(posedge clk) begin
    if (start) begin
      job       <= q_data;
      pos       <= q_data.home;
      step      <= (q_data.count == CNT_W'(1)) ? IDX_W'(0) : IDX_W'(1);
      issue_cnt <= '0;
    end else if (issue) begin
      cmp_pos   <= pos;
      cmp_last  <= (CNT_W'(issue_cnt + CNT_W'(1)) == job.count);
      issue_cnt <= issue_cnt + CNT_W'(1);
      pos       <= pos_next;
      step      <= step_next;
    end
    if (done) begin
      if (hit) begin
        out_status <= (job.op == OP_INSERT) ? ST_INSERTED : ST_DELETED;
        out_index  <= cmp_pos;
      end else begin
        out_status <= (job.op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
        out_index  <= '0;
      end
    end
  end

  // key memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) key_mem[cmp_pos] <= job.key;
    rd_key <= key_mem[pos];
  end

  assign empty      = !out_valid;
  assign status     = out_status;
  assign slot_index = out_index;

endmodule

@@ hdl/quadratic_probe_hash_table.sv @@
// top level of the quadratic probe hash table
// depends on qpht_pkg, qpht_front, qpht_queue, qpht_back and the macros header
//
//   channel   handshake           payload
//   input     push / full         opcode, key_digits
//   result    empty / pop         status, slot_index
//   config    cfg_write           cfg_data (slot_count)
//
// the front takes one item at a time: accept, fold, 15 remainder steps, hand-off
// the back reads the key memory once per probe, up to slot_count (clamped to 1..64)
// probes, and a miss probes them all; front and back overlap
// the front stalls only when the two-entry queue is full; the back starts an
// item only when the result register is empty
// rst clears the slot flags, queue and config (slot_count back to 64) at once
`include "quadratic_probe_hash_table_macros.svh"

module quadratic_probe_hash_table import qpht_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic             opcode,
  input  logic [KEY_W-1:0] key_digits,
  output logic             empty,
  input  logic             pop,
  output logic [1:0]       status,
  output logic [IDX_W-1:0] slot_index,
  input  logic             cfg_write,
  input  logic [CNT_W-1:0] cfg_data
);

  logic [CNT_W-1:0] slot_count;
  logic             f_push;
  logic             q_full;
  job_t             f_job;
  logic             q_pop;
  logic             q_empty;
  job_t             q_job;
  logic             res_miss;

  // slot count register
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= CNT_RESET;
    end else if (cfg_write) begin
      slot_count <= cfg_data;
    end
  end

  qpht_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .opcode     (opcode),
    .key_digits (key_digits),
    .slot_count (slot_count),
    .q_push     (f_push),
    .q_full     (q_full),
    .q_data     (f_job)
  );

  qpht_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (f_push),
    .wr_data (f_job),
    .q_full  (q_full),
    .rd      (q_pop),
    .rd_data (q_job),
    .q_empty (q_empty)
  );

  qpht_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_data     (q_job),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .status     (status),
    .slot_index (slot_index)
  );

  // result item that reports no slot
  assign res_miss = (status == ST_FULL) || (status == ST_NOT_FOUND);

  // a miss always reports slot zero
  `QPHT_ASSERT_IMPL(a_miss_index, clk, rst, !empty && res_miss, slot_index == '0)
  // an accepted item keeps the front busy the next cycle
  `QPHT_ASSERT_NEXT(a_accept_busy, clk, rst, push && !full, full)
  // the back takes a queued item only while the result register is free
  `QPHT_ASSERT_IMPL(a_start_free, clk, rst, q_pop, empty && !q_empty)

endmodule
